>>> hw/rtl/qvr_pkg.sv
// Package for the quaternion vector rotation block: fixed-point widths,
// component types and the payload structs passed between pipeline stages.
// No dependencies.
package qvr_pkg;

	// Fraction bits removed by each rounding step (Q16.16 x Q2.14 -> Q16.16).
	localparam int FRAC_SHIFT = 14;
	localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);

	localparam int VEC_W  = 32;
	localparam int QC_W   = 16;
	localparam int T_W    = 36;
	localparam int R_W    = 40;
	localparam int PROD1_W = VEC_W + QC_W;
	localparam int PROD2_W = T_W + QC_W;
	localparam int SUM1_W = T_W + FRAC_SHIFT;
	localparam int SUM2_W = R_W + FRAC_SHIFT;

	typedef logic signed [VEC_W-1:0]   vec_comp_t;
	typedef logic signed [QC_W-1:0]    quat_comp_t;
	typedef logic signed [T_W-1:0]     t_comp_t;
	typedef logic signed [R_W-1:0]     r_comp_t;
	typedef logic signed [PROD1_W-1:0] prod1_t;
	typedef logic signed [PROD2_W-1:0] prod2_t;
	typedef logic signed [SUM1_W-1:0]  sum1_t;
	typedef logic signed [SUM2_W-1:0]  sum2_t;

	localparam vec_comp_t VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam vec_comp_t VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	typedef struct packed {
		vec_comp_t x;
		vec_comp_t y;
		vec_comp_t z;
	} vec3_t;

	typedef struct packed {
		quat_comp_t w;
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
	} quat_t;

	// Intermediate quaternion t = conj(q) * (0, v), rounded to Q.16.
	typedef struct packed {
		t_comp_t w;
		t_comp_t x;
		t_comp_t y;
		t_comp_t z;
	} tquat_t;

	// Rounded vector part of t * q, before saturation.
	typedef struct packed {
		r_comp_t x;
		r_comp_t y;
		r_comp_t z;
	} rvec_t;

endpackage

>>> hw/rtl/qvr_conj_mul.sv
// First product stage pair: t = conj(q) * (0, v), twelve products then
// rounded sums. Depends on qvr_pkg.
module qvr_conj_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  qvr_pkg::vec3_t  vec,
	input  qvr_pkg::quat_t  quat,
	output logic            t_valid,
	output qvr_pkg::tquat_t t,
	output qvr_pkg::quat_t  t_quat
);
	import qvr_pkg::*;

	logic   valid_s1, valid_s2;
	quat_t  quat_s1, quat_s2;
	tquat_t t_s2;
	// Product names give the quaternion part then the vector component.
	prod1_t p_av0_s1, p_bv1_s1, p_cv2_s1;
	prod1_t p_wv0_s1, p_bv2_s1, p_cv1_s1;
	prod1_t p_wv1_s1, p_cv0_s1, p_av2_s1;
	prod1_t p_wv2_s1, p_av1_s1, p_bv0_s1;
	sum1_t  sum_w, sum_x, sum_y, sum_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_av0_s1 <= $signed(quat.x) * $signed(vec.x);
		p_bv1_s1 <= $signed(quat.y) * $signed(vec.y);
		p_cv2_s1 <= $signed(quat.z) * $signed(vec.z);
		p_wv0_s1 <= $signed(quat.w) * $signed(vec.x);
		p_bv2_s1 <= $signed(quat.y) * $signed(vec.z);
		p_cv1_s1 <= $signed(quat.z) * $signed(vec.y);
		p_wv1_s1 <= $signed(quat.w) * $signed(vec.y);
		p_cv0_s1 <= $signed(quat.z) * $signed(vec.x);
		p_av2_s1 <= $signed(quat.x) * $signed(vec.z);
		p_wv2_s1 <= $signed(quat.w) * $signed(vec.z);
		p_av1_s1 <= $signed(quat.x) * $signed(vec.y);
		p_bv0_s1 <= $signed(quat.y) * $signed(vec.x);
		quat_s1  <= quat;
	end

	// The conjugate negates x, y and z; the signs are folded into the sums.
	always_comb begin
		sum_w = sum1_t'(p_av0_s1) + sum1_t'(p_bv1_s1) + sum1_t'(p_cv2_s1)
			+ sum1_t'(ROUND_BIAS);
		sum_x = sum1_t'(p_wv0_s1) - sum1_t'(p_bv2_s1) + sum1_t'(p_cv1_s1)
			+ sum1_t'(ROUND_BIAS);
		sum_y = sum1_t'(p_wv1_s1) - sum1_t'(p_cv0_s1) + sum1_t'(p_av2_s1)
			+ sum1_t'(ROUND_BIAS);
		sum_z = sum1_t'(p_wv2_s1) - sum1_t'(p_av1_s1) + sum1_t'(p_bv0_s1)
			+ sum1_t'(ROUND_BIAS);
	end

	always_ff @(posedge clk) begin
		t_s2.w  <= sum_w[FRAC_SHIFT +: T_W];
		t_s2.x  <= sum_x[FRAC_SHIFT +: T_W];
		t_s2.y  <= sum_y[FRAC_SHIFT +: T_W];
		t_s2.z  <= sum_z[FRAC_SHIFT +: T_W];
		quat_s2 <= quat_s1;
	end

	assign t_valid = valid_s2;
	assign t       = t_s2;
	assign t_quat  = quat_s2;

endmodule

>>> hw/rtl/qvr_rot_mul.sv
// Second product stage pair: vector part of t * q, twelve products then
// rounded sums. Depends on qvr_pkg.
module qvr_rot_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            t_valid,
	input  qvr_pkg::tquat_t t,
	input  qvr_pkg::quat_t  quat,
	output logic            r_valid,
	output qvr_pkg::rvec_t  r
);
	import qvr_pkg::*;

	logic   valid_s3, valid_s4;
	rvec_t  r_s4;
	prod2_t p_t0a_s3, p_t1w_s3, p_t2c_s3, p_t3b_s3;
	prod2_t p_t0b_s3, p_t2w_s3, p_t3a_s3, p_t1c_s3;
	prod2_t p_t0c_s3, p_t3w_s3, p_t1b_s3, p_t2a_s3;
	sum2_t  sum_x, sum_y, sum_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= t_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_t0a_s3 <= $signed(t.w) * $signed(quat.x);
		p_t1w_s3 <= $signed(t.x) * $signed(quat.w);
		p_t2c_s3 <= $signed(t.y) * $signed(quat.z);
		p_t3b_s3 <= $signed(t.z) * $signed(quat.y);
		p_t0b_s3 <= $signed(t.w) * $signed(quat.y);
		p_t2w_s3 <= $signed(t.y) * $signed(quat.w);
		p_t3a_s3 <= $signed(t.z) * $signed(quat.x);
		p_t1c_s3 <= $signed(t.x) * $signed(quat.z);
		p_t0c_s3 <= $signed(t.w) * $signed(quat.z);
		p_t3w_s3 <= $signed(t.z) * $signed(quat.w);
		p_t1b_s3 <= $signed(t.x) * $signed(quat.y);
		p_t2a_s3 <= $signed(t.y) * $signed(quat.x);
	end

	always_comb begin
		sum_x = sum2_t'(p_t0a_s3) + sum2_t'(p_t1w_s3) + sum2_t'(p_t2c_s3)
			- sum2_t'(p_t3b_s3) + sum2_t'(ROUND_BIAS);
		sum_y = sum2_t'(p_t0b_s3) + sum2_t'(p_t2w_s3) + sum2_t'(p_t3a_s3)
			- sum2_t'(p_t1c_s3) + sum2_t'(ROUND_BIAS);
		sum_z = sum2_t'(p_t0c_s3) + sum2_t'(p_t3w_s3) + sum2_t'(p_t1b_s3)
			- sum2_t'(p_t2a_s3) + sum2_t'(ROUND_BIAS);
	end

	always_ff @(posedge clk) begin
		r_s4.x <= sum_x[FRAC_SHIFT +: R_W];
		r_s4.y <= sum_y[FRAC_SHIFT +: R_W];
		r_s4.z <= sum_z[FRAC_SHIFT +: R_W];
	end

	assign r_valid = valid_s4;
	assign r       = r_s4;

endmodule

>>> hw/rtl/qvr_clip.sv
// Output stage: saturates each rounded component to the Q16.16 range and
// raises the clip flag. Depends on qvr_pkg.
module qvr_clip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               r_valid,
	input  qvr_pkg::rvec_t     r,
	output logic               out_valid,
	output qvr_pkg::vec3_t     out_vec,
	output logic               out_sat
);
	import qvr_pkg::*;

	logic  valid_s5, sat_s5;
	vec3_t vec_s5;
	logic  hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;

	// A component overflows when its bits above the 32-bit sign differ from it.
	always_comb begin
		hi_x = !r.x[R_W-1] && (r.x[R_W-2:VEC_W-1] != '0);
		lo_x =  r.x[R_W-1] && (r.x[R_W-2:VEC_W-1] != '1);
		hi_y = !r.y[R_W-1] && (r.y[R_W-2:VEC_W-1] != '0);
		lo_y =  r.y[R_W-1] && (r.y[R_W-2:VEC_W-1] != '1);
		hi_z = !r.z[R_W-1] && (r.z[R_W-2:VEC_W-1] != '0);
		lo_z =  r.z[R_W-1] && (r.z[R_W-2:VEC_W-1] != '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_s5.x <= hi_x ? VEC_MAX : (lo_x ? VEC_MIN : r.x[VEC_W-1:0]);
		vec_s5.y <= hi_y ? VEC_MAX : (lo_y ? VEC_MIN : r.y[VEC_W-1:0]);
		vec_s5.z <= hi_z ? VEC_MAX : (lo_z ? VEC_MIN : r.z[VEC_W-1:0]);
		sat_s5   <= hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
	end

	assign out_valid = valid_s5;
	assign out_vec   = vec_s5;
	assign out_sat   = sat_s5;

	// A flagged result has at least one component sitting on a range limit.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && sat_s5) |-> (vec_s5.x == VEC_MAX || vec_s5.x == VEC_MIN ||
			vec_s5.y == VEC_MAX || vec_s5.y == VEC_MIN ||
			vec_s5.z == VEC_MAX || vec_s5.z == VEC_MIN))
		else $error("clip flag set with no component at a limit");

	// An unflagged result is the rounded value unchanged; the x component is checked.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !(hi_x | lo_x | hi_y | lo_y | hi_z | lo_z)) |=>
			(vec_s5.x == $past(r.x[VEC_W-1:0]) && !sat_s5))
		else $error("in-range component altered by the clip stage");

endmodule

>>> hw/rtl/quaternion_vector_rotation_top.sv
// Top level of the quaternion vector rotation block: rotates a Q16.16 vector
// by a Q2.14 quaternion as conj(q) * v * q. Depends on qvr_pkg, qvr_conj_mul,
// qvr_rot_mul and qvr_clip.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-----------------------------------
//   request   | in        | start, busy        | vec_x/y/z, quat_w/x/y/z
//   result    | out       | done (one cycle)   | out_x/y/z, saturated
//
// A request is taken at every rising edge where start is high and busy is low.
// busy is held low: the pipeline has no stall and takes one request per clock.
// Each result leaves with done, for one cycle, from the saturation stage.
// The depth is set by the two multiplier banks, each followed by a rounded
// adder stage, and the final saturation stage.
// Reset clears only the valid bits; the data registers need no reset.
module quaternion_vector_rotation_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  qvr_pkg::vec_comp_t     vec_x,
	input  qvr_pkg::vec_comp_t     vec_y,
	input  qvr_pkg::vec_comp_t     vec_z,
	input  qvr_pkg::quat_comp_t    quat_w,
	input  qvr_pkg::quat_comp_t    quat_x,
	input  qvr_pkg::quat_comp_t    quat_y,
	input  qvr_pkg::quat_comp_t    quat_z,
	output logic                   done,
	output qvr_pkg::vec_comp_t     out_x,
	output qvr_pkg::vec_comp_t     out_y,
	output qvr_pkg::vec_comp_t     out_z,
	output logic                   saturated
);
	import qvr_pkg::*;

	// Cycles from an accepted request to its result strobe.
	localparam int LATENCY = 5;

	logic   in_valid;
	vec3_t  in_vec;
	quat_t  in_quat;

	logic   t_valid;
	tquat_t t;
	quat_t  t_quat;

	logic   r_valid;
	rvec_t  r;

	vec3_t  res_vec;

	// The pipeline never holds anything off, so a request is always taken.
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	assign in_vec  = '{x: vec_x, y: vec_y, z: vec_z};
	assign in_quat = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};

	// Stages one and two: products of the conjugate with the vector, then
	// the rounded intermediate quaternion. The quaternion is carried along
	// for the second product.
	qvr_conj_mul u_conj_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.vec      (in_vec),
		.quat     (in_quat),
		.t_valid  (t_valid),
		.t        (t),
		.t_quat   (t_quat)
	);

	// Stages three and four: products of the intermediate with the original
	// quaternion, then the rounded vector part. The scalar part is not formed.
	qvr_rot_mul u_rot_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.t_valid (t_valid),
		.t       (t),
		.quat    (t_quat),
		.r_valid (r_valid),
		.r       (r)
	);

	// Stage five: saturation to the 32-bit range, registered onto the ports.
	qvr_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.r_valid   (r_valid),
		.r         (r),
		.out_valid (done),
		.out_vec   (res_vec),
		.out_sat   (saturated)
	);

	assign out_x = res_vec.x;
	assign out_y = res_vec.y;
	assign out_z = res_vec.z;

	// Every request produces exactly one result, a fixed number of cycles on.
	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not produce a result strobe");

	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching request");

	// A zero quaternion must give the zero vector without a clip flag.
	a_zero_quat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0)
			|-> ##LATENCY (out_x == '0 && out_y == '0 && out_z == '0 && !saturated))
		else $error("zero quaternion gave a non-zero result");

endmodule
